// ----- hdl/ssct_pkg.sv -----
package ssct_pkg;

  // Coordinate width; radii are one bit narrower
  localparam int COORD_BITS = 24;
  localparam int RAD_W      = COORD_BITS - 1;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int MAG_W      = COORD_BITS;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int DSQ_W      = SQ_W + 2;
  localparam int RS_W       = COORD_BITS;
  localparam int SSQ_W      = 2 * RS_W;
  localparam int WIDE_W     = DSQ_W + 1;

  // Result field widths
  localparam int GAP_W  = 51;
  localparam int DIR_W  = 16;

  // Direction lane: quotient d^2 * 2^30 / D, then integer square root
  localparam int QUO_W      = 31;
  localparam int ROOT_W     = 16;
  localparam int SR_W       = QUO_W + 2;
  localparam int LANE_LAT   = QUO_W + ROOT_W + 1;
  localparam int FRONT_LAT  = 3;
  localparam int PIPE_DEPTH = FRONT_LAT + LANE_LAT;

  // Beat layouts
  localparam int IN_BITS  = 6 * COORD_BITS + 2 * RAD_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 1 + GAP_W + 3 * DIR_W + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam int IN_FCX = 0;
  localparam int IN_FCY = IN_FCX + COORD_BITS;
  localparam int IN_FCZ = IN_FCY + COORD_BITS;
  localparam int IN_FR  = IN_FCZ + COORD_BITS;
  localparam int IN_SCX = IN_FR + RAD_W;
  localparam int IN_SCY = IN_SCX + COORD_BITS;
  localparam int IN_SCZ = IN_SCY + COORD_BITS;
  localparam int IN_SR  = IN_SCZ + COORD_BITS;

  // Results that ride beside the direction lanes
  typedef struct packed {
    logic             hit;
    logic             coincident;
    logic [GAP_W-1:0] gap;
  } side_t;

endpackage

// ----- hdl/ssct_lane.sv -----
module ssct_lane (
  input  logic                             clk,
  input  logic                             en,
  input  logic [ssct_pkg::SQ_W-1:0]        sq_in,
  input  logic [ssct_pkg::DSQ_W-1:0]       dsq_in,
  input  logic                             neg_in,
  output logic [ssct_pkg::DIR_W-1:0]       dir_out
);

  localparam int QW = ssct_pkg::QUO_W;
  localparam int RW = ssct_pkg::ROOT_W;
  localparam int DW = ssct_pkg::DSQ_W;
  localparam int SW = ssct_pkg::SR_W;

  logic [DW-1:0]   rem_r [QW];
  logic [DW-1:0]   den_r [QW];
  logic [QW-1:0]   quo_r [QW];
  logic            dneg_r [QW];

  logic [RW-1:0]   root_r [RW];
  logic [QW-1:0]   srem_r [RW];
  logic            sneg_r [RW];

  logic [ssct_pkg::DIR_W-1:0] dir_r;

  // Restoring division, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DW:0]   trial;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic          neg_d;
    logic          take;

    if (k == 0) begin : g_first
      assign trial  = {1'b0, DW'(sq_in)};
      assign den_in = dsq_in;
      assign quo_in = '0;
      assign neg_d  = neg_in;
    end else begin : g_next
      assign trial  = {rem_r[k-1], 1'b0};
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
      assign neg_d  = dneg_r[k-1];
    end

    assign take = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? DW'(trial - {1'b0, den_in}) : DW'(trial);
        den_r[k]  <= den_in;
        quo_r[k]  <= {quo_in[QW-2:0], take};
        dneg_r[k] <= neg_d;
      end
    end
  end

  // Integer square root, one root bit per stage
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam int B = RW - 1 - j;
    logic [RW-1:0] root_in;
    logic [QW-1:0] rem_in;
    logic          neg_s;
    logic [SW-1:0] inc;
    logic          take;

    if (j == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = quo_r[QW-1];
      assign neg_s   = dneg_r[QW-1];
    end else begin : g_next
      assign root_in = root_r[j-1];
      assign rem_in  = srem_r[j-1];
      assign neg_s   = sneg_r[j-1];
    end

    assign inc  = (SW'(root_in) << (B + 1)) | (SW'(1) << (2 * B));
    assign take = (SW'(rem_in) >= inc);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[j] <= take ? (root_in | (RW'(1) << B)) : root_in;
        srem_r[j] <= take ? QW'(SW'(rem_in) - inc) : rem_in;
        sneg_r[j] <= neg_s;
      end
    end
  end

  // Halve the root, rounding to nearest, and apply the sign
  logic [RW:0]                half_up;
  logic [ssct_pkg::DIR_W-1:0] mag;

  assign half_up = ({1'b0, root_r[RW-1]} + (RW+1)'(1)) >> 1;
  assign mag     = ssct_pkg::DIR_W'(half_up);

  always_ff @(posedge clk) begin
    if (en) begin
      dir_r <= sneg_r[RW-1] ? (ssct_pkg::DIR_W'(0) - mag) : mag;
    end
  end

  assign dir_out = dir_r;

endmodule

// ----- hdl/sphere_sphere_collision_test.sv -----
// Sphere pair intersection test.
// Input channel in_*: one beat per sphere pair; in_tdata carries both centers
// (signed Q12.12) and both radii (unsigned Q11.12). Output channel out_*:
// one beat per pair with the hit flag, the gap (squared radius sum minus
// squared center distance, signed Q.24), the unit direction from
// the first center to the second in Q1.14 and the coincident flag.
// From input beat to output beat a pair passes three front stages
// (difference, squares, sum), 31 division stages and 16 square root stages
// per direction component, and the output register.
// Throughput is one pair per cycle unless stalled; up to 51 pairs in flight.
// The whole pipeline advances together; when out_tready is low while an
// output beat is waiting, every stage holds and in_tready drops, so no beat
// is lost or repeated. Bubbles inside the pipeline hold as well.
// Synchronous reset clears all valid bits; data registers are not reset.
module sphere_sphere_collision_test (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // first_center_x, first_center_y, first_center_z, first_radius,
  // second_center_x, second_center_y, second_center_z, second_radius
  input  logic [ssct_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // hit, overlap_gap, dir_x, dir_y, dir_z, coincident
  output logic [ssct_pkg::OUT_W-1:0]  out_tdata
);

  localparam int CB = ssct_pkg::COORD_BITS;
  localparam int DW = ssct_pkg::DIFF_W;
  localparam int MW = ssct_pkg::MAG_W;
  localparam int QW = ssct_pkg::SQ_W;
  localparam int GW = ssct_pkg::GAP_W;
  localparam int XW = ssct_pkg::WIDE_W;
  localparam int LL = ssct_pkg::LANE_LAT;
  localparam int PD = ssct_pkg::PIPE_DEPTH;

  logic en;
  logic vld_r [PD];

  assign en        = !vld_r[PD-1] || out_tready;
  assign in_tready = en;

  // Valid bits move with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PD; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < PD; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Stage 1: center differences, magnitudes, radius sum
  logic signed [DW-1:0] d_nxt [3];
  logic [MW-1:0]        mag_r [3];
  logic                 neg_r [3];
  logic [ssct_pkg::RS_W-1:0] rs_r;

  always_comb begin
    d_nxt[0] = DW'($signed(in_tdata[ssct_pkg::IN_SCX +: CB]))
             - DW'($signed(in_tdata[ssct_pkg::IN_FCX +: CB]));
    d_nxt[1] = DW'($signed(in_tdata[ssct_pkg::IN_SCY +: CB]))
             - DW'($signed(in_tdata[ssct_pkg::IN_FCY +: CB]));
    d_nxt[2] = DW'($signed(in_tdata[ssct_pkg::IN_SCZ +: CB]))
             - DW'($signed(in_tdata[ssct_pkg::IN_FCZ +: CB]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= d_nxt[i][DW-1];
        mag_r[i] <= d_nxt[i][DW-1] ? MW'(-d_nxt[i]) : MW'(d_nxt[i]);
      end
      rs_r <= ssct_pkg::RS_W'(in_tdata[ssct_pkg::IN_FR +: ssct_pkg::RAD_W])
            + ssct_pkg::RS_W'(in_tdata[ssct_pkg::IN_SR +: ssct_pkg::RAD_W]);
    end
  end

  // Stage 2: squares
  logic [QW-1:0]              sq2_r  [3];
  logic                       neg2_r [3];
  logic [ssct_pkg::SSQ_W-1:0] ssq2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq2_r[i]  <= QW'(mag_r[i] * mag_r[i]);
        neg2_r[i] <= neg_r[i];
      end
      ssq2_r <= ssct_pkg::SSQ_W'(rs_r * rs_r);
    end
  end

  // Stage 3: squared distance
  logic [QW-1:0]                sq3_r  [3];
  logic                         neg3_r [3];
  logic [ssct_pkg::SSQ_W-1:0]   ssq3_r;
  logic [ssct_pkg::DSQ_W-1:0]   dsq3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq3_r  <= sq2_r;
      neg3_r <= neg2_r;
      ssq3_r <= ssq2_r;
      dsq3_r <= ssct_pkg::DSQ_W'(sq2_r[0]) + ssct_pkg::DSQ_W'(sq2_r[1])
              + ssct_pkg::DSQ_W'(sq2_r[2]);
    end
  end

  // Hit, gap and coincidence, delayed to meet the direction lanes
  logic signed [XW-1:0] diff;
  logic [GW-1:0]        gap_sat;
  ssct_pkg::side_t      side_nxt;
  ssct_pkg::side_t      side_r [LL];

  assign diff = $signed(XW'(ssq3_r)) - $signed(XW'(dsq3_r));

  if (XW <= GW) begin : g_gap_fit
    assign gap_sat = GW'(diff);
  end else begin : g_gap_sat
    logic signed [XW-1:0] gmax;
    logic signed [XW-1:0] gmin;
    assign gmax = XW'({1'b0, {(GW-1){1'b1}}});
    assign gmin = -gmax - XW'(1);
    assign gap_sat = (diff > gmax) ? GW'(gmax) : (diff < gmin) ? GW'(gmin) : GW'(diff);
  end

  always_comb begin
    side_nxt.hit        = (dsq3_r < ssct_pkg::DSQ_W'(ssq3_r));
    side_nxt.coincident = (dsq3_r == '0);
    side_nxt.gap        = gap_sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int i = 1; i < LL; i++) side_r[i] <= side_r[i-1];
    end
  end

  // Direction lanes
  logic [ssct_pkg::DIR_W-1:0] dir [3];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    ssct_lane u_lane (
      .clk     (clk),
      .en      (en),
      .sq_in   (sq3_r[c]),
      .dsq_in  (dsq3_r),
      .neg_in  (neg3_r[c]),
      .dir_out (dir[c])
    );
  end

  // Output beat
  ssct_pkg::side_t side_out;
  assign side_out = side_r[LL-1];

  assign out_tvalid = vld_r[PD-1];
  assign out_tdata  = ssct_pkg::OUT_W'({
    side_out.coincident,
    side_out.coincident ? ssct_pkg::DIR_W'(0) : dir[2],
    side_out.coincident ? ssct_pkg::DIR_W'(0) : dir[1],
    side_out.coincident ? ssct_pkg::DIR_W'(0) : dir[0],
    side_out.gap,
    side_out.hit
  });

endmodule

// ----- hdl/ssct_checker.sv -----
module ssct_assertions (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [ssct_pkg::OUT_W-1:0]  out_tdata
);

  // Hold a stalled beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  // Coincident centers give a zero direction
  a_coinc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[100] |-> out_tdata[99:52] == '0)
    else $error("direction not zero for coincident centers");

  // Hit agrees with a positive gap
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[0] == (!out_tdata[51] && out_tdata[51:1] != '0))
    else $error("hit flag disagrees with gap");

  // No output beat right after reset
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind sphere_sphere_collision_test ssct_assertions u_ssct_assertions (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
